FILE: src/sdf_pkg.sv
// -----------------------------------------------------------------------------
// sdf_pkg
// Shared sizes, types and helpers of the stream duplicate filter.
// -----------------------------------------------------------------------------
package sdf_pkg;

  localparam int unsigned MAX_UNIQUE = 64;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned UCOUNT_W   = 7;
  localparam int unsigned UCOUNT_MAX = (1 << UCOUNT_W) - 1;
  localparam int unsigned CNT_W      = $clog2(MAX_UNIQUE + 1);
  localparam int unsigned ADDR_W     = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // Clamp the stored count to the width of the result field.
  function automatic logic [UCOUNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [UCOUNT_W-1:0] r;
    if ((CNT_W > UCOUNT_W) && (c > CNT_W'(UCOUNT_MAX))) begin
      r = UCOUNT_W'(UCOUNT_MAX);
    end else begin
      r = UCOUNT_W'(c);
    end
    return r;
  endfunction

endpackage

FILE: src/sdf_ram.sv
// -----------------------------------------------------------------------------
// sdf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// -----------------------------------------------------------------------------
module sdf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

FILE: src/stream_duplicate_filter_core.sv
// -----------------------------------------------------------------------------
// stream_duplicate_filter_core
// Passes every item on with a flag: kept for the first occurrence of each value of an array, clear for repeats.
// -----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  in      | input     | in_valid_i/in_ready_o | value_i, last_i
//  out     | output    | out_valid_o/out_ready_i | value_out_o, kept_o,
//          |           |                       | unique_count_o, overflow_o,
//          |           |                       | last_out_o
//
// Each item is checked against the N distinct values already held for the array
// (up to MAX_UNIQUE): the store RAM is scanned one entry a cycle through its
// single read port, and a repeat ends the scan at its match.
// One item is in work at a time.
// Reset empties the store at once (the count is cleared, the RAM is not).
// A result waits in the output register; the next item is accepted meanwhile
// and its scan runs, only its final step holds until the register is free.
// -----------------------------------------------------------------------------
module stream_duplicate_filter_core
  import sdf_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [VALUE_W-1:0]  value_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [VALUE_W-1:0]  value_out_o,
  output logic                       kept_o,
  output logic [UCOUNT_W-1:0]        unique_count_o,
  output logic                       overflow_o,
  output logic                       last_out_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic               found_q, found_d;
  logic [VALUE_W-1:0] value_q;
  logic               last_q;

  logic               out_valid_q;
  logic [VALUE_W-1:0] value_out_q;
  logic               kept_q;
  logic [UCOUNT_W-1:0] ucount_q;
  logic               ovf_out_q;
  logic               last_out_q;

  logic               in_fire;
  logic               slot_free;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic               wr_en;
  logic               load_out;
  logic               hit;
  logic               scan_end;
  logic               has_room;
  logic               new_kept;
  logic [CNT_W-1:0]   cnt_new;
  logic               ovf_new;

  assign in_fire   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign hit       = (rd_data == value_q);
  assign scan_end  = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;
  assign has_room  = cnt_q < CNT_W'(MAX_UNIQUE);
  assign new_kept  = !found_q && has_room;
  assign cnt_new   = new_kept ? cnt_q + CNT_W'(1) : cnt_q;
  assign ovf_new   = ovf_q || (!found_q && !has_room);

  sdf_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_UNIQUE)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[ADDR_W-1:0]),
    .wr_data_i (value_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (cnt_q == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || scan_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    load_out   = 1'b0;
    idx_d      = idx_q;
    found_d    = found_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        rd_en      = in_valid_i;
        idx_d      = '0;
        found_d    = 1'b0;
      end
      S_SCAN: begin
        // fetch the next entry while comparing the current one
        rd_en   = !(hit || scan_end);
        rd_addr = idx_q + ADDR_W'(1);
        if (hit) begin
          found_d = 1'b1;
        end else if (!scan_end) begin
          idx_d = idx_q + ADDR_W'(1);
        end
      end
      S_DONE: begin
        load_out = slot_free;
        wr_en    = slot_free && new_kept;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (load_out) begin
      // end of array: empty the store
      cnt_d = last_q ? '0 : cnt_new;
      ovf_d = last_q ? 1'b0 : ovf_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      value_q <= value_i;
      last_q  <= last_i;
    end
    if (load_out) begin
      value_out_q <= value_q;
      kept_q      <= new_kept;
      ucount_q    <= sat_count(cnt_new);
      ovf_out_q   <= ovf_new;
      last_out_q  <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_out_o    = value_out_q;
  assign kept_o         = kept_q;
  assign unique_count_o = ucount_q;
  assign overflow_o     = ovf_out_q;
  assign last_out_o     = last_out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_UNIQUE))
    else $error("stored count above store depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> CNT_W'(idx_q) < cnt_q)
    else $error("scan index past stored entries");

  a_kept_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kept_o |-> unique_count_o != '0)
    else $error("kept item with zero count");

  a_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && !last_q |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("store write without count advance");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ready_o)
    else $error("input taken while an item is in work");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Checks the stream duplicate filter against an in-bench dedup predictor:
// a directed table covering extremes, repeats, array ends and store overflow,
// then random arrays of mixed length and value spread, with random idling on
// both channels and one long output hold-off that backs up the input.
// -----------------------------------------------------------------------------
module testbench;
  import sdf_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 2 * (MAX_UNIQUE + 2);
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      kept;
    logic [UCOUNT_W-1:0]       count;
    logic                      ovf;
    logic                      last;
  } dedup_result_t;

  // One table row: reps elements value, value+1, ...; last only on the final one.
  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic                last;
    int unsigned         reps;
    logic                typed;
    logic                kept;
    logic [UCOUNT_W-1:0] cnt;
    logic                ovf;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 17;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // single-element array
    '{32'h0000_0000, 1'b1, 1,  1'b1, 1'b1, 7'd1,  1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1,  1'b1, 1'b1, 7'd1,  1'b0},
    '{32'h8000_0000, 1'b0, 1,  1'b1, 1'b1, 7'd2,  1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1,  1'b1, 1'b0, 7'd2,  1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1,  1'b1, 1'b1, 7'd3,  1'b0},
    '{32'h0000_0000, 1'b0, 1,  1'b1, 1'b1, 7'd4,  1'b0},
    // array ends on a repeat
    '{32'h8000_0000, 1'b1, 1,  1'b1, 1'b0, 7'd4,  1'b0},
    '{32'h8000_0000, 1'b1, 1,  1'b1, 1'b1, 7'd1,  1'b0},
    '{32'h5555_5555, 1'b1, 1,  1'b1, 1'b1, 7'd1,  1'b0},
    // fill the store, then overflow with a new value
    '{32'h0001_0000, 1'b0, 64, 1'b0, 1'b0, 7'd0,  1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1,  1'b1, 1'b0, 7'd64, 1'b1},
    '{32'h0001_0000, 1'b0, 1,  1'b1, 1'b0, 7'd64, 1'b1},
    '{32'hAAAA_AAAA, 1'b1, 1,  1'b1, 1'b0, 7'd64, 1'b1},
    '{32'hAAAA_AAAA, 1'b1, 1,  1'b1, 1'b1, 7'd1,  1'b0},
    // fill to exactly full at the array end, no overflow
    '{32'hFFFF_FFC0, 1'b0, 63, 1'b0, 1'b0, 7'd0,  1'b0},
    '{32'h1234_5678, 1'b1, 1,  1'b1, 1'b1, 7'd64, 1'b0},
    '{32'h1234_5678, 1'b1, 1,  1'b1, 1'b1, 7'd1,  1'b0}
  };

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] value_in = '0;
  logic                      last_in = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] value_out;
  logic                      kept_out;
  logic [UCOUNT_W-1:0]       count_out;
  logic                      ovf_out;
  logic                      last_out;

  // predictor state
  logic [VALUE_W-1:0] held_vals [MAX_UNIQUE];
  int unsigned        held_n = 0;
  logic               ovf_flag = 1'b0;

  dedup_result_t pending_results [$];
  int unsigned   mismatches = 0;
  int unsigned   item_count = 0;
  int unsigned   cycle_count = 0;
  bit            calm = 1'b0;
  bit            hold_out_req = 1'b0;

  stream_duplicate_filter_core u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .value_i        (value_in),
    .last_i         (last_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .value_out_o    (value_out),
    .kept_o         (kept_out),
    .unique_count_o (count_out),
    .overflow_o     (ovf_out),
    .last_out_o     (last_out)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic dedup_result_t dedup_predict(input logic signed [VALUE_W-1:0] v,
                                                  input logic l);
    dedup_result_t r;
    bit            hit;
    hit = 1'b0;
    for (int unsigned i = 0; i < held_n; i++) begin
      if (held_vals[i] == v) hit = 1'b1;
    end
    r.kept = 1'b0;
    if (!hit) begin
      if (held_n < MAX_UNIQUE) begin
        held_vals[held_n] = v;
        held_n++;
        r.kept = 1'b1;
      end else begin
        ovf_flag = 1'b1;
      end
    end
    r.value = v;
    r.count = (held_n > UCOUNT_MAX) ? UCOUNT_W'(UCOUNT_MAX) : UCOUNT_W'(held_n);
    r.ovf   = ovf_flag;
    r.last  = l;
    // empty the store once the array ends
    if (l) begin
      held_n   = 0;
      ovf_flag = 1'b0;
    end
    return r;
  endfunction

  task automatic offer_item(input logic signed [VALUE_W-1:0] v, input logic l,
                            input logic typed, input dedup_result_t typed_res);
    dedup_result_t pred;
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value_in <= v;
    last_in  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = dedup_predict(v, l);
    pending_results.push_back(typed ? typed_res : pred);
    item_count++;
  endtask

  task automatic report_field(input string name, input logic [VALUE_W-1:0] got,
                              input logic [VALUE_W-1:0] want);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // result side: check each accepted item, stall at random
  initial begin
    dedup_result_t want;
    bit            hold_taken;
    hold_taken = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h %b %0d %b %b",
                   $time, value_out, kept_out, count_out, ovf_out, last_out);
        end else begin
          want = pending_results.pop_front();
          report_field("value_out", value_out, want.value);
          report_field("kept", VALUE_W'(kept_out), VALUE_W'(want.kept));
          report_field("unique_count", VALUE_W'(count_out), VALUE_W'(want.count));
          report_field("overflow", VALUE_W'(ovf_out), VALUE_W'(want.ovf));
          report_field("last_out", VALUE_W'(last_out), VALUE_W'(want.last));
        end
      end
      if (hold_out_req && !hold_taken) begin
        // hold off long enough for the block to back up its input
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // item side: directed table, then random arrays
  initial begin
    dedup_result_t                 typed_res;
    logic signed [VALUE_W-1:0]     pool [$];
    logic signed [VALUE_W-1:0]     arr [$];
    logic signed [VALUE_W-1:0]     v;
    logic signed [VALUE_W-1:0]     base;
    int unsigned                   kind;
    int unsigned                   len;
    int unsigned                   pool_n;
    int unsigned                   rand_start;
    bit                            hold_done;

    hold_done = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      for (int unsigned k = 0; k < dir_rows[r].reps; k++) begin
        v = dir_rows[r].value + k;
        typed_res.value = v;
        typed_res.kept  = dir_rows[r].kept;
        typed_res.count = dir_rows[r].cnt;
        typed_res.ovf   = dir_rows[r].ovf;
        typed_res.last  = dir_rows[r].last && (k == dir_rows[r].reps - 1);
        offer_item(v, typed_res.last, dir_rows[r].typed, typed_res);
      end
    end

    rand_start = item_count;
    while (item_count < rand_start + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      pool.delete();
      arr.delete();
      if (kind < 60) begin
        len = $urandom_range(1, 12);
        pool_n = $urandom_range(1, 6);
      end else if (kind < 85) begin
        len = $urandom_range(13, 40);
        pool_n = $urandom_range(8, 24);
      end else if (kind < 88) begin
        len = $urandom_range(66, 80);
        pool_n = 0;
      end else begin
        len = $urandom_range(1, 20);
        pool_n = 0;
      end
      for (int unsigned p = 0; p < pool_n; p++) begin
        case ($urandom_range(0, 9))
          0: pool.push_back(32'h7FFF_FFFF);
          1: pool.push_back(32'h8000_0000);
          2: pool.push_back($urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF);
          default: pool.push_back($urandom);
        endcase
      end
      base = $urandom;
      for (int unsigned e = 0; e < len; e++) begin
        calm = (item_count >= rand_start + 1000) && (item_count < rand_start + 1250);
        if (!hold_done && item_count >= rand_start + 700) begin
          hold_done    = 1'b1;
          hold_out_req = 1'b1;
        end
        if (pool_n != 0) begin
          v = pool[$urandom_range(0, pool_n - 1)];
        end else if (kind < 88) begin
          // mostly distinct, with some repeats to hit the full store
          if (arr.size() != 0 && $urandom_range(0, 99) < 20) begin
            v = arr[$urandom_range(0, arr.size() - 1)];
          end else begin
            v = base + e;
          end
        end else begin
          v = $urandom;
        end
        arr.push_back(v);
        offer_item(v, e == len - 1, 1'b0, '0);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/sdf_pkg.sv
src/sdf_ram.sv
src/stream_duplicate_filter_core.sv
dv/testbench.sv
